// ===== rtl/core/nna_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nna_pkg
// Words, status codes and opcode groups of the network node ALU.
// ----------------------------------------------------------------------------
package nna_pkg;

  typedef struct packed {
    logic [7:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] constant;
    logic signed [31:0] sensor_front;
    logic signed [31:0] sensor_back;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] node_value;
    logic [2:0]         status;
  } out_word_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_DIV_ZERO   = 3'd1;
  localparam logic [2:0] ST_POW_SAT    = 3'd2;
  localparam logic [2:0] ST_BAD_OP     = 3'd3;
  localparam logic [2:0] ST_BAD_SENSOR = 3'd4;

  localparam logic [7:0] OP_SENSOR = 8'd24;
  localparam logic [7:0] OP_ABS    = 8'd16;

  localparam logic [6:0] GRP_ADD  = 7'd0;
  localparam logic [6:0] GRP_SUB  = 7'd1;
  localparam logic [6:0] GRP_MUL  = 7'd2;
  localparam logic [6:0] GRP_DIV  = 7'd3;
  localparam logic [6:0] GRP_MOD  = 7'd4;
  localparam logic [6:0] GRP_MAX  = 7'd5;
  localparam logic [6:0] GRP_MIN  = 7'd6;
  localparam logic [6:0] GRP_POW  = 7'd7;
  localparam logic [6:0] GRP_UNI  = 7'd8;
  localparam logic [6:0] GRP_EQ   = 7'd9;
  localparam logic [6:0] GRP_GT   = 7'd10;
  localparam logic [6:0] GRP_LT   = 7'd11;

  typedef enum logic [1:0] {
    KIND_SIMPLE,
    KIND_DIV,
    KIND_MOD,
    KIND_POW
  } kind_e;

endpackage

// ===== rtl/core/nna_iter_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nna_iter_stage
// One registered stage: one restoring divide bit and, when IDX < EB, one
// square-and-multiply step of the power, with sideband carried along.
// ----------------------------------------------------------------------------
module nna_iter_stage #(
  parameter int W      = 32,
  parameter int IDX    = 0,
  parameter int EB     = 5,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SIDE_W-1:0] side_i,
  input  logic [W-1:0]      num_i,
  input  logic [W-1:0]      den_i,
  input  logic [W-1:0]      rem_i,
  input  logic [W-1:0]      quo_i,
  input  logic [W-1:0]      base_i,
  input  logic [W-1:0]      acc_i,
  input  logic [W-1:0]      cl_i,
  input  logic [EB-1:0]     expo_i,
  output logic              valid_o,
  output logic [SIDE_W-1:0] side_o,
  output logic [W-1:0]      num_o,
  output logic [W-1:0]      den_o,
  output logic [W-1:0]      rem_o,
  output logic [W-1:0]      quo_o,
  output logic [W-1:0]      base_o,
  output logic [W-1:0]      acc_o,
  output logic [W-1:0]      cl_o,
  output logic [EB-1:0]     expo_o
);

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic [W-1:0] rem_d;
  logic [W-1:0] quo_d;
  logic [W-1:0] base_d;
  logic [W-1:0] acc_d;
  logic         valid_q;

  always_comb begin
    trial = {rem_i, num_i[W-1-IDX]};
    diff  = trial - {1'b0, den_i};
    if (!diff[W]) begin
      rem_d = diff[W-1:0];
      quo_d = quo_i | (W'(1) << (W-1-IDX));
    end else begin
      rem_d = trial[W-1:0];
      quo_d = quo_i;
    end
  end

  if (IDX < EB) begin : g_pow
    logic [2*W-1:0] sq;
    logic [2*W-1:0] pr;
    always_comb begin
      sq     = base_i * base_i;
      pr     = acc_i * base_i;
      base_d = (sq > {{W{1'b0}}, cl_i}) ? cl_i : sq[W-1:0];
      if (expo_i[IDX]) begin
        acc_d = (pr > {{W{1'b0}}, cl_i}) ? cl_i : pr[W-1:0];
      end else begin
        acc_d = acc_i;
      end
    end
  end else begin : g_pass
    always_comb begin
      base_d = base_i;
      acc_d  = acc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      num_o  <= num_i;
      den_o  <= den_i;
      rem_o  <= rem_d;
      quo_o  <= quo_d;
      base_o <= base_d;
      acc_o  <= acc_d;
      cl_o   <= cl_i;
      expo_o <= expo_i;
    end
  end

  assign valid_o = valid_q;

endmodule

// ===== rtl/core/network_node_alu_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// network_node_alu_unit
// Evaluates one computation-net node per word through a fixed pipeline.
// ----------------------------------------------------------------------------
// Stages: decode, one stage per divide bit, output.
// Throughput: one word per cycle while the output is not stalled; the divide bit chain sets the depth.
// A stalled output holds the whole pipeline.
// Reset clears all valid bits; data registers are not reset.
module network_node_alu_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nna_pkg::in_word_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nna_pkg::out_word_t out_data_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int EB = $clog2(W);
  localparam logic [W-1:0] EX_LIM  = W'(VALUE_WIDTH);
  localparam logic [W-1:0] MAX_V   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_V   = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    nna_pkg::kind_e kind;
    logic [2:0]     status;
    logic [W-1:0]   sval;
    logic           qneg;
    logic           rneg;
    logic           pneg;
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  logic                en;
  logic signed [W-1:0] a, b, c, y;
  logic [6:0]          grp;
  logic signed [W:0]   msum;
  logic signed [W:0]   mq;
  logic [W-1:0]        prod;
  logic [W-1:0]        mag;
  side_t               side_d;
  logic [W-1:0]        num_d, den_d, base_d, cl_d;
  logic [EB-1:0]       expo_d;

  logic                valid_s [W+1];
  logic [SIDE_W-1:0]   side_s  [W+1];
  logic [W-1:0]        num_s   [W+1];
  logic [W-1:0]        den_s   [W+1];
  logic [W-1:0]        rem_s   [W+1];
  logic [W-1:0]        quo_s   [W+1];
  logic [W-1:0]        base_s  [W+1];
  logic [W-1:0]        acc_s   [W+1];
  logic [W-1:0]        cl_s    [W+1];
  logic [EB-1:0]       expo_s  [W+1];

  side_t               side_l;
  logic [W-1:0]        vfin;
  logic [2:0]          sfin;
  logic                out_valid_q;
  nna_pkg::out_word_t  out_data_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    a    = W'(in_data_i.operand_a);
    b    = W'(in_data_i.operand_b);
    c    = W'(in_data_i.constant);
    y    = in_data_i.opcode[0] ? b : c;
    grp  = in_data_i.opcode[7:1];
    msum = {a[W-1], a} + {b[W-1], b};
    mq   = msum >>> 1;
    if (msum[W] && msum[0]) begin
      mq = mq + (W+1)'(1);
    end
    prod = a * y;
    mag  = a[W-1] ? (W'(0) - a) : a;

    side_d.kind   = nna_pkg::KIND_SIMPLE;
    side_d.status = nna_pkg::ST_OK;
    side_d.sval   = '0;
    side_d.qneg   = a[W-1] ^ y[W-1];
    side_d.rneg   = a[W-1];
    side_d.pneg   = a[W-1] && y[0];
    num_d         = mag;
    den_d         = y[W-1] ? (W'(0) - y) : y;
    base_d        = mag;
    expo_d        = y[EB-1:0];
    cl_d          = (a[W-1] && y[0]) ? (MIN_V + W'(1)) : MIN_V;

    if (in_data_i.opcode > nna_pkg::OP_SENSOR) begin
      side_d.status = nna_pkg::ST_BAD_OP;
    end else if (in_data_i.opcode == nna_pkg::OP_SENSOR) begin
      if (in_data_i.constant == 32'sd0) begin
        side_d.sval = W'(in_data_i.sensor_front);
      end else if (in_data_i.constant == 32'sd1) begin
        side_d.sval = W'(in_data_i.sensor_back);
      end else begin
        side_d.status = nna_pkg::ST_BAD_SENSOR;
      end
    end else begin
      case (grp)
        nna_pkg::GRP_ADD: side_d.sval = a + y;
        nna_pkg::GRP_SUB: side_d.sval = a - y;
        nna_pkg::GRP_MUL: side_d.sval = prod;
        nna_pkg::GRP_DIV, nna_pkg::GRP_MOD: begin
          if (y == '0) begin
            side_d.status = nna_pkg::ST_DIV_ZERO;
          end else begin
            side_d.kind = (grp == nna_pkg::GRP_DIV) ? nna_pkg::KIND_DIV : nna_pkg::KIND_MOD;
          end
        end
        nna_pkg::GRP_MAX: side_d.sval = (a > y) ? a : y;
        nna_pkg::GRP_MIN: side_d.sval = (a < y) ? a : y;
        nna_pkg::GRP_POW: begin
          if (y == '0) begin
            side_d.sval = W'(1);
          end else if (y[W-1]) begin
            if (a == W'(1)) begin
              side_d.sval = W'(1);
            end else if (a == {W{1'b1}}) begin
              side_d.sval = y[0] ? {W{1'b1}} : W'(1);
            end else if (a == '0) begin
              side_d.sval   = MAX_V;
              side_d.status = nna_pkg::ST_POW_SAT;
            end
          end else if (mag <= W'(1)) begin
            side_d.sval = side_d.pneg ? (W'(0) - mag) : mag;
          end else if (y >= EX_LIM) begin
            side_d.sval   = side_d.pneg ? MIN_V : MAX_V;
            side_d.status = nna_pkg::ST_POW_SAT;
          end else begin
            side_d.kind = nna_pkg::KIND_POW;
          end
        end
        nna_pkg::GRP_UNI: begin
          if (in_data_i.opcode == nna_pkg::OP_ABS) begin
            side_d.sval = mag;
          end else begin
            side_d.sval = mq[W-1:0];
          end
        end
        nna_pkg::GRP_EQ: side_d.sval = W'(a == y);
        nna_pkg::GRP_GT: side_d.sval = W'(a > y);
        default:         side_d.sval = W'(a < y);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_s[0] <= 1'b0;
    end else if (en) begin
      valid_s[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_s[0] <= side_d;
      num_s[0]  <= num_d;
      den_s[0]  <= den_d;
      rem_s[0]  <= '0;
      quo_s[0]  <= '0;
      base_s[0] <= base_d;
      acc_s[0]  <= W'(1);
      cl_s[0]   <= cl_d;
      expo_s[0] <= expo_d;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_stage
    nna_iter_stage #(
      .W      (W),
      .IDX    (k),
      .EB     (EB),
      .SIDE_W (SIDE_W)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[k]),
      .side_i  (side_s[k]),
      .num_i   (num_s[k]),
      .den_i   (den_s[k]),
      .rem_i   (rem_s[k]),
      .quo_i   (quo_s[k]),
      .base_i  (base_s[k]),
      .acc_i   (acc_s[k]),
      .cl_i    (cl_s[k]),
      .expo_i  (expo_s[k]),
      .valid_o (valid_s[k+1]),
      .side_o  (side_s[k+1]),
      .num_o   (num_s[k+1]),
      .den_o   (den_s[k+1]),
      .rem_o   (rem_s[k+1]),
      .quo_o   (quo_s[k+1]),
      .base_o  (base_s[k+1]),
      .acc_o   (acc_s[k+1]),
      .cl_o    (cl_s[k+1]),
      .expo_o  (expo_s[k+1])
    );
  end

  always_comb begin
    side_l = side_t'(side_s[W]);
    sfin   = side_l.status;
    case (side_l.kind)
      nna_pkg::KIND_DIV: vfin = side_l.qneg ? (W'(0) - quo_s[W]) : quo_s[W];
      nna_pkg::KIND_MOD: vfin = side_l.rneg ? (W'(0) - rem_s[W]) : rem_s[W];
      nna_pkg::KIND_POW: begin
        if (acc_s[W] >= cl_s[W]) begin
          vfin = side_l.pneg ? MIN_V : MAX_V;
          sfin = nna_pkg::ST_POW_SAT;
        end else begin
          vfin = side_l.pneg ? (W'(0) - acc_s[W]) : acc_s[W];
        end
      end
      default: vfin = side_l.sval;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_s[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q.node_value <= 32'(signed'(vfin));
      out_data_q.status     <= sfin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_div_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.status == nna_pkg::ST_DIV_ZERO |-> out_data_q.node_value == 32'sd0)
    else $error("divide by zero word carries a nonzero value");

  a_bad_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_data_q.status == nna_pkg::ST_BAD_OP ||
                    out_data_q.status == nna_pkg::ST_BAD_SENSOR)
    |-> out_data_q.node_value == 32'sd0)
    else $error("error word carries a nonzero value");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_data_q.status <= nna_pkg::ST_BAD_SENSOR)
    else $error("status code out of range");

endmodule
